// File: src/bpa_pkg.sv
// Package: types, constants and helpers for the bitmap page allocator.
`default_nettype none

package bpa_pkg;

    localparam int NUM_PAGES   = 256;
    localparam int MAX_REQUEST = 16;
    localparam int RESULT_CAP  = 16;
    localparam int REQ_LIMIT   = (MAX_REQUEST < RESULT_CAP) ? MAX_REQUEST : RESULT_CAP;

    localparam int GRP_SIZE    = (NUM_PAGES < 16) ? 8 : 16;
    localparam int GRP_SHIFT   = $clog2(GRP_SIZE);
    localparam int NUM_GROUPS  = (NUM_PAGES + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GRP_IDX_W   = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int FT_W        = $clog2(NUM_PAGES + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_GRANTED = 2'd0,
        ST_FAILED  = 2'd1,
        ST_FREED   = 2'd2
    } t_status;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        CMD_ALLOC_BAD = 2'd0,
        CMD_ALLOC     = 2'd1,
        CMD_FREE      = 2'd2
    } t_cmd_kind;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_SCAN = 1'b1
    } t_bk_state;

    typedef struct packed {
        logic       req_type;
        logic [4:0] page_count;
        logic [7:0] free_page;
        logic       group_last;
    } t_req;

    typedef struct packed {
        logic [7:0] page_number;
        t_status    status;
        logic       last_result;
    } t_result;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [4:0] count;
        logic [7:0] page;
        logic       in_range;
        logic       ack;
    } t_cmd;

    // Pages past the end of the map read as used so the search never takes them.
    function automatic logic [GRP_SIZE-1:0] grp_reset(input int g);
        logic [GRP_SIZE-1:0] w;
        w = '0;
        for (int j = 0; j < GRP_SIZE; j++) begin
            if (g * GRP_SIZE + j >= NUM_PAGES) begin
                w[j] = 1'b1;
            end
        end
        return w;
    endfunction

    function automatic logic [GRP_SHIFT-1:0] lowest_zero(input logic [GRP_SIZE-1:0] w);
        logic [GRP_SIZE-1:0]  onehot;
        logic [GRP_SHIFT-1:0] idx;
        onehot = ~w & (w + GRP_SIZE'(1));
        idx    = '0;
        for (int j = 0; j < GRP_SIZE; j++) begin
            if (onehot[j]) begin
                idx = idx | GRP_SHIFT'(j);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// File: src/bpa_front.sv
// Front end: request decode and command queue.
`default_nettype none

module bpa_front
    import bpa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_req i_req,
    output logic      o_busy,
    output logic      o_cmd_valid,
    output t_cmd      o_cmd,
    input  wire logic i_cmd_pop
);

    t_cmd              r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    t_cmd              w_cmd;
    logic              w_push;
    logic              w_pop;

    always_comb begin
        w_cmd          = '0;
        w_cmd.count    = i_req.page_count;
        w_cmd.page     = i_req.free_page;
        w_cmd.ack      = i_req.group_last;
        w_cmd.in_range = (32'(i_req.free_page) < NUM_PAGES);
        if (i_req.req_type == REQ_FREE) begin
            w_cmd.kind = CMD_FREE;
        end else if (i_req.page_count == 5'd0 || 32'(i_req.page_count) > REQ_LIMIT) begin
            w_cmd.kind = CMD_ALLOC_BAD;
        end else begin
            w_cmd.kind = CMD_ALLOC;
        end
    end

    assign o_busy      = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];
    assign w_push      = i_start && !o_busy;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: src/bpa_back.sv
// Back end: used-page map, free count, first-fit scan and result register.
`default_nettype none

module bpa_back
    import bpa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    output logic      o_valid,
    output t_result   o_result
);

    t_bk_state            r_state;
    t_bk_state            n_state;
    logic [GRP_SIZE-1:0]  r_map [NUM_GROUPS];
    logic [GRP_SIZE-1:0]  n_map [NUM_GROUPS];
    logic [FT_W-1:0]      r_free_total;
    logic [FT_W-1:0]      n_free_total;
    logic [4:0]           r_left;
    logic [4:0]           n_left;
    logic [GRP_IDX_W-1:0] r_grp;
    logic [GRP_IDX_W-1:0] n_grp;
    logic                 r_valid;
    logic                 n_valid;
    t_result              r_result;
    t_result              n_result;

    logic [GRP_SIZE-1:0]  w_word;
    logic [GRP_SHIFT-1:0] w_bit;
    logic [7:0]           w_page;
    logic [GRP_IDX_W-1:0] w_fgrp;
    logic [GRP_SHIFT-1:0] w_fbit;

    assign w_word = r_map[r_grp];
    assign w_bit  = lowest_zero(w_word);
    assign w_page = 8'({r_grp, w_bit});
    assign w_fgrp = GRP_IDX_W'(32'(i_cmd.page) >> GRP_SHIFT);
    assign w_fbit = i_cmd.page[GRP_SHIFT-1:0];

    always_comb begin
        n_state      = r_state;
        n_map        = r_map;
        n_free_total = r_free_total;
        n_left       = r_left;
        n_grp        = r_grp;
        n_valid      = 1'b0;
        n_result     = '0;
        o_cmd_pop    = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        CMD_ALLOC_BAD: begin
                            n_valid              = 1'b1;
                            n_result.status      = ST_FAILED;
                            n_result.last_result = 1'b1;
                        end
                        CMD_ALLOC: begin
                            if (32'(i_cmd.count) > 32'(r_free_total)) begin
                                n_valid              = 1'b1;
                                n_result.status      = ST_FAILED;
                                n_result.last_result = 1'b1;
                            end else begin
                                n_left  = i_cmd.count;
                                n_grp   = '0;
                                n_state = BK_SCAN;
                            end
                        end
                        CMD_FREE: begin
                            if (i_cmd.in_range && r_map[w_fgrp][w_fbit]) begin
                                n_map[w_fgrp][w_fbit] = 1'b0;
                                n_free_total          = r_free_total + FT_W'(1);
                            end
                            if (i_cmd.ack) begin
                                n_valid              = 1'b1;
                                n_result.status      = ST_FREED;
                                n_result.last_result = 1'b1;
                            end
                        end
                        default: begin
                            n_valid = 1'b0;
                        end
                    endcase
                end
            end
            BK_SCAN: begin
                if (!(&w_word)) begin
                    n_map[r_grp][w_bit]  = 1'b1;
                    n_free_total         = r_free_total - FT_W'(1);
                    n_left               = r_left - 5'd1;
                    n_valid              = 1'b1;
                    n_result.page_number = w_page;
                    n_result.status      = ST_GRANTED;
                    n_result.last_result = (r_left == 5'd1);
                    if (r_left == 5'd1) begin
                        n_state = BK_IDLE;
                    end
                end else begin
                    n_grp = r_grp + GRP_IDX_W'(1);
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_IDLE;
            r_free_total <= FT_W'(NUM_PAGES);
            r_valid      <= 1'b0;
            r_left       <= '0;
            r_grp        <= '0;
            for (int g = 0; g < NUM_GROUPS; g++) begin
                r_map[g] <= grp_reset(g);
            end
        end else begin
            r_state      <= n_state;
            r_free_total <= n_free_total;
            r_valid      <= n_valid;
            r_left       <= n_left;
            r_grp        <= n_grp;
            r_map        <= n_map;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// File: src/bitmap_page_allocator.sv
// Bitmap first-fit page allocator: top level.
// A failed allocate or free acknowledgement goes via the command queue and result register.
// A granted run of n pages gives one word per cycle while the first-fit scan finds a free
// page in its current group of 16 pages; it gives none while it steps over a full group.
// busy rises when the four-entry command queue is full; results cannot be stalled.
// Synchronous reset marks every page free and empties the queue.
`default_nettype none

module bitmap_page_allocator
    import bpa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_req i_req,
    output logic      busy,
    output logic      o_valid,
    output t_result   o_result
);

    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_pop;

    bpa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_req),
        .o_busy      (busy),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    bpa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

// File: src/bpa_checker.sv
// Port checker for the bitmap page allocator and its bind.
`default_nettype none

module bpa_checker
    import bpa_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    busy,
    input wire logic    o_valid,
    input wire t_result o_result
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !busy)
        else $error("result or busy right after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.status == ST_GRANTED || o_result.status == ST_FAILED
                     || o_result.status == ST_FREED))
        else $error("undefined status code");

    a_single_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.status != ST_GRANTED
            |-> o_result.last_result && o_result.page_number == 8'd0)
        else $error("failure or acknowledge word malformed");

    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.status == ST_GRANTED
            && $past(o_valid && o_result.status == ST_GRANTED && !o_result.last_result)
            |-> o_result.page_number > $past(o_result.page_number))
        else $error("granted pages not ascending within a run");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

`default_nettype wire

// File: bench/tb_bitmap_page_allocator.sv
// Testbench for bitmap_page_allocator: directed and random requests checked against a page map model.
`timescale 1ns / 100ps

module tb_bitmap_page_allocator;
    import bpa_pkg::*;

    class page_ledger;
        bit [NUM_PAGES-1:0] taken;
        int                 free_cnt;
        t_result            owed[$];
        int                 errors;

        function new();
            taken    = '0;
            free_cnt = NUM_PAGES;
            errors   = 0;
        endfunction

        function void log_error(string msg);
            errors++;
            if (errors <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function void push_word(int page, t_status st, bit last);
            t_result e;
            e.page_number = 8'(page);
            e.status      = st;
            e.last_result = last;
            owed.push_back(e);
        endfunction

        function void take_request(t_req r);
            int want;
            int given;
            if (r.req_type == REQ_ALLOC) begin
                want = r.page_count;
                if (want == 0 || want > REQ_LIMIT || want > free_cnt) begin
                    push_word(0, ST_FAILED, 1'b1);
                end else begin
                    given = 0;
                    for (int p = 0; p < NUM_PAGES && given < want; p++) begin
                        if (!taken[p]) begin
                            taken[p] = 1'b1;
                            given++;
                            push_word(p, ST_GRANTED, given == want);
                        end
                    end
                    free_cnt -= given;
                end
            end else begin
                if (taken[r.free_page]) begin
                    taken[r.free_page] = 1'b0;
                    free_cnt++;
                end
                if (r.group_last) begin
                    push_word(0, ST_FREED, 1'b1);
                end
            end
        endfunction

        function void match_result(t_result got);
            t_result e;
            if (owed.size() == 0) begin
                log_error($sformatf("unexpected word: page %0d status %0d last %0d",
                                    got.page_number, got.status, got.last_result));
                return;
            end
            e = owed.pop_front();
            if (got.page_number !== e.page_number || got.status !== e.status ||
                got.last_result !== e.last_result) begin
                log_error($sformatf("mismatch: expected page %0d status %0d last %0d, got page %0d status %0d last %0d",
                                    e.page_number, e.status, e.last_result,
                                    got.page_number, got.status, got.last_result));
            end
        endfunction
    endclass

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    t_req    i_req;
    logic    busy;
    logic    o_valid;
    t_result o_result;

    page_ledger ledger = new();

    bitmap_page_allocator u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            ledger.match_result(o_result);
        end
    end

    initial begin
        #1_000_000;
        $display("tb_bitmap_page_allocator: done, errors");
        $finish;
    end

    function automatic t_req alloc_req(int n);
        t_req r;
        r.req_type   = REQ_ALLOC;
        r.page_count = 5'(n);
        r.free_page  = 8'($urandom);
        r.group_last = 1'($urandom);
        return r;
    endfunction

    function automatic t_req free_req(int page, bit last);
        t_req r;
        r.req_type   = REQ_FREE;
        r.page_count = 5'($urandom);
        r.free_page  = 8'(page);
        r.group_last = last;
        return r;
    endfunction

    function automatic int taken_from(int first);
        int q;
        for (int i = 0; i < NUM_PAGES; i++) begin
            q = (first + i) % NUM_PAGES;
            if (ledger.taken[q]) begin
                return q;
            end
        end
        return first;
    endfunction

    task automatic issue(t_req r, int pct);
        while ($urandom_range(0, 99) < pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        ledger.take_request(r);
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (ledger.owed.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_phase(int n, int pct);
        int   done;
        int   roll;
        int   bias;
        t_req r;
        bit   counts;
        done = 0;
        while (done < n) begin
            roll   = $urandom_range(0, 99);
            counts = 1'b1;
            bias   = (ledger.free_cnt < 64) ? 75 : ((ledger.free_cnt > 192) ? 25 : 50);
            if (roll < 5) begin
                r = alloc_req($urandom_range(0, 31));
            end else if (roll < 10) begin
                r      = free_req($urandom_range(0, NUM_PAGES - 1), $urandom_range(0, 1));
                counts = ledger.taken[r.free_page] || r.group_last;
            end else if (ledger.free_cnt == NUM_PAGES || $urandom_range(0, 99) >= bias) begin
                if ($urandom_range(0, 9) < 7) begin
                    r = alloc_req($urandom_range(1, 4));
                end else begin
                    r = alloc_req($urandom_range(1, REQ_LIMIT));
                end
            end else begin
                r = free_req(taken_from($urandom_range(0, NUM_PAGES - 1)),
                             $urandom_range(0, 3) == 0);
            end
            issue(r, pct);
            if (counts) begin
                done++;
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        issue(alloc_req(1), 0);
        issue(alloc_req(REQ_LIMIT), 0);
        issue(alloc_req(0), 0);
        issue(alloc_req(REQ_LIMIT + 1), 0);
        issue(alloc_req(31), 0);
        issue(free_req(0, 1'b0), 0);
        issue(free_req(0, 1'b1), 0);
        issue(free_req(NUM_PAGES - 1, 1'b1), 0);
        issue(alloc_req(2), 0);
        while (ledger.free_cnt >= REQ_LIMIT) begin
            issue(alloc_req(REQ_LIMIT), 0);
        end
        issue(alloc_req(REQ_LIMIT), 0);
        issue(free_req(NUM_PAGES - 1, 1'b1), 0);
        drain();

        run_phase(133, 21);
        drain();
        run_phase(133, 82);
        drain();
        run_phase(134, 0);
        drain();
        repeat (40) @(posedge i_clk);

        if (ledger.errors == 0) begin
            $display("tb_bitmap_page_allocator: done, clean");
        end else begin
            $display("tb_bitmap_page_allocator: done, errors");
        end
        $finish;
    end

endmodule
